/* hw/rtl/c3f_pkg.sv */
// Shared types, constants and helpers of the 3x3 convolution filter.
package c3f_pkg;

    // Configuration port geometry
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 24;

    // Register indexes of the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        CFG_COEF_TOP  = 3'd0,
        CFG_COEF_MID  = 3'd1,
        CFG_COEF_BOT  = 3'd2,
        CFG_WIDTH     = 3'd3,
        CFG_HEIGHT    = 3'd4,
        CFG_GAIN      = 3'd5
    } t_cfg_idx;

    // Register reset values
    localparam logic [23:0] CoefTopRst = 24'hFFFFFF;
    localparam logic [23:0] CoefMidRst = 24'hFEFFFF;
    localparam logic [23:0] CoefBotRst = 24'hFFFFFF;
    localparam logic [15:0] WidthRst   = 16'd32768;
    localparam logic [15:0] HeightRst  = 16'd32768;
    localparam logic [23:0] GainRst    = 24'd68182;

    // Result format
    localparam int OutW     = 24;
    localparam int OutMax   = 8388607;
    localparam int OutMin   = -8388608;
    localparam int FracDrop = 16;
    localparam int RoundBias = 32768;

    // Queue between the front and the back
    localparam int QueueDepth = 4;
    localparam int QPtrW      = 2;
    localparam int QCntW      = 3;

    // Window taps, row-major: top left .. bottom right
    localparam int WinTaps = 9;

    // Kernel rows, left coefficient in the low byte
    typedef struct packed {
        logic [23:0] bot;
        logic [23:0] mid;
        logic [23:0] top;
    } t_coef_set;

    // Frame geometry as written
    typedef struct packed {
        logic [15:0] height;
        logic [15:0] width;
    } t_geom;

    // Pick the signed coefficient of one column from a kernel row
    function automatic logic signed [7:0] coef_at(input logic [23:0] row, input int col);
        coef_at = $signed(row[8*col +: 8]);
    endfunction

endpackage

/* hw/rtl/c3f_ifs.sv */
// Stream and configuration channels of the 3x3 convolution filter.

interface c3f_pix_if #(parameter int PIXEL_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface c3f_res_if import c3f_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [OutW-1:0] filtered;
    logic                   frame_last;
    modport source (output valid, output filtered, output frame_last, input ready);
    modport sink (input valid, input filtered, input frame_last, output ready);
endinterface

interface c3f_cfg_if import c3f_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/c3f_queue.sv */
// Short FIFO that decouples the window front from the arithmetic back.
module c3f_queue import c3f_pkg::*; #(
    parameter int WIDTH = 109
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic [QCntW-1:0] o_count,
    output logic             o_pop_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data
);

    logic [WIDTH-1:0] r_buf [QueueDepth];
    logic [QPtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCntW-1:0] r_count, n_count;

    // Advance pointers and fill level
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + QPtrW'(1) : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + QPtrW'(1) : r_rd_ptr;
        n_count  = r_count + QCntW'(i_push) - QCntW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_count     = r_count;
    assign o_pop_valid = (r_count != '0);
    assign o_pop_data  = r_buf[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && r_count == QCntW'(QueueDepth)))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == '0))
        else $error("queue underflow");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[QPtrW-1:0])
        else $error("queue pointers disagree with fill level");

endmodule

/* hw/rtl/c3f_front.sv */
// Front part: pixel intake, raster counters, line stores and the 3x3 window.
module c3f_front import c3f_pkg::*; #(
    parameter int MAX_WIDTH  = 32768,
    parameter int PIXEL_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    c3f_pix_if.sink                        i_pix,
    input  t_geom                          i_geom,
    input  logic [QCntW-1:0]               i_q_count,
    output logic                           o_push,
    output logic [WinTaps-1:0][PIXEL_BITS-1:0] o_push_win,
    output logic                           o_push_last
);

    localparam int ColW = $clog2(MAX_WIDTH);
    localparam logic [16:0] MaxW = 17'(MAX_WIDTH);

    // Line stores: a holds the previous row, b the one before it
    logic [PIXEL_BITS-1:0] mem_line_a [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] mem_line_b [MAX_WIDTH];

    logic [ColW-1:0]       r_col, n_col;
    logic [15:0]           r_row, n_row;
    logic                  r_s1_valid;
    logic [PIXEL_BITS-1:0] r_s1_px;
    logic [ColW-1:0]       r_s1_idx;
    logic                  r_s1_emit;
    logic                  r_s1_last;
    logic [PIXEL_BITS-1:0] r_rd_a;
    logic [PIXEL_BITS-1:0] r_rd_b;
    logic [PIXEL_BITS-1:0] r_win [6];

    logic [16:0]    w_wclamp;
    logic [ColW-1:0] w_last_col;
    logic [15:0]    w_last_row;
    logic           w_row_end;
    logic           w_frame_end;
    logic           w_emit;
    logic           w_accept;
    logic [QCntW:0] w_pending;

    // Clamp geometry and classify the arriving pixel
    always_comb begin
        if ({1'b0, i_geom.width} < 17'd3) begin
            w_wclamp = 17'd3;
        end else if ({1'b0, i_geom.width} > MaxW) begin
            w_wclamp = MaxW;
        end else begin
            w_wclamp = {1'b0, i_geom.width};
        end
        w_last_col  = ColW'(w_wclamp - 17'd1);
        w_last_row  = (i_geom.height < 16'd3) ? 16'd2 : i_geom.height - 16'd1;
        w_row_end   = (r_col >= w_last_col);
        w_frame_end = w_row_end && (r_row >= w_last_row);
        w_emit      = (r_row >= 16'd2) && (r_col >= ColW'(2));
    end

    // Take a pixel only when the queue has room for everything in flight
    always_comb begin
        w_pending   = (QCntW+1)'(i_q_count) + (QCntW+1)'(r_s1_valid);
        i_pix.ready = i_rst_n && (w_pending < (QCntW+1)'(QueueDepth));
        w_accept    = i_pix.valid && i_pix.ready;
    end

    // Step the raster position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            if (w_row_end) begin
                n_col = '0;
                n_row = w_frame_end ? '0 : r_row + 16'd1;
            end else begin
                n_col = r_col + ColW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
            r_s1_last  <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= w_accept;
            if (w_accept) begin
                r_s1_emit <= w_emit;
                r_s1_last <= w_frame_end;
            end
        end
    end

    // Hold the pixel and its column while the line stores are read
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_px  <= i_pix.pixel;
            r_s1_idx <= r_col;
        end
    end

    // Line store a: read at intake, write the new pixel in the next cycle
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            mem_line_a[r_s1_idx] <= r_s1_px;
        end
        if (w_accept) begin
            r_rd_a <= mem_line_a[r_col];
        end
    end

    // Line store b: takes the row that leaves line store a
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            mem_line_b[r_s1_idx] <= r_rd_a;
        end
        if (w_accept) begin
            r_rd_b <= mem_line_b[r_col];
        end
    end

    // Shift the window by one column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_s1_valid) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= r_rd_b;
            r_win[1] <= r_rd_a;
            r_win[2] <= r_s1_px;
        end
    end

    // Hand a complete window to the queue
    always_comb begin
        o_push        = r_s1_valid && r_s1_emit;
        o_push_last   = r_s1_last;
        o_push_win[0] = r_win[3];
        o_push_win[1] = r_win[0];
        o_push_win[2] = r_rd_b;
        o_push_win[3] = r_win[4];
        o_push_win[4] = r_win[1];
        o_push_win[5] = r_rd_a;
        o_push_win[6] = r_win[5];
        o_push_win[7] = r_win[2];
        o_push_win[8] = r_s1_px;
    end

    a_last_is_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |-> r_s1_emit)
        else $error("frame end flagged on a border pixel");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_frame_end) |=> (r_row == '0 && r_col == '0))
        else $error("raster counters did not wrap at frame end");

    a_room_at_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_q_count < QCntW'(QueueDepth)))
        else $error("window pushed into a full queue");

endmodule

/* hw/rtl/c3f_back.sv */
// Back part: nine products, sum, gain scaling, rounding and saturation.
module c3f_back import c3f_pkg::*; #(
    parameter int PIXEL_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_coef_set                          i_coef,
    input  logic [23:0]                        i_gain,
    input  logic                               i_q_valid,
    input  logic [WinTaps-1:0][PIXEL_BITS-1:0] i_q_win,
    input  logic                               i_q_last,
    output logic                               o_pop,
    c3f_res_if.source                          o_res
);

    localparam int ProdW = PIXEL_BITS + 9;
    localparam int RowW  = ProdW + 2;
    localparam int SumW  = ProdW + 4;
    localparam int ScW   = SumW + 25;
    localparam logic signed [ScW:0] SatHi = (ScW+1)'(OutMax);
    localparam logic signed [ScW:0] SatLo = (ScW+1)'(OutMin);
    localparam logic signed [ScW:0] Bias  = (ScW+1)'(RoundBias);

    logic                    w_adv;
    logic [23:0]             w_rows [3];
    logic signed [ProdW-1:0] n_prod [WinTaps];
    logic signed [ScW:0]     w_rnd;
    logic signed [ScW:0]     w_shift;
    logic signed [OutW-1:0]  n_out;

    logic                    r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_out_valid;
    logic                    r_s1_last, r_s2_last, r_s3_last, r_s4_last, r_out_last;
    logic signed [ProdW-1:0] r_prod [WinTaps];
    logic signed [RowW-1:0]  r_row_sum [3];
    logic signed [SumW-1:0]  r_sum;
    logic signed [ScW-1:0]   r_scaled;
    logic signed [OutW-1:0]  r_out;

    // The whole back moves whenever the output register is free
    assign w_adv = !r_out_valid || o_res.ready;
    assign o_pop = i_q_valid && w_adv;

    // Multiply each tap by its coefficient
    always_comb begin
        w_rows[0] = i_coef.top;
        w_rows[1] = i_coef.mid;
        w_rows[2] = i_coef.bot;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[r*3+c] = ProdW'($signed({1'b0, i_q_win[r*3+c]}) * coef_at(w_rows[r], c));
            end
        end
    end

    // Round at bit 16 towards plus infinity on ties, then clip
    always_comb begin
        w_rnd   = (ScW+1)'(r_scaled) + Bias;
        w_shift = w_rnd >>> FracDrop;
        if (w_shift > SatHi) begin
            n_out = OutW'(SatHi);
        end else if (w_shift < SatLo) begin
            n_out = OutW'(SatLo);
        end else begin
            n_out = OutW'(w_shift);
        end
    end

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= i_q_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid;
        end
    end

    // Data stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < WinTaps; k++) begin
                r_prod[k] <= n_prod[k];
            end
            r_s1_last <= i_q_last;

            for (int r = 0; r < 3; r++) begin
                r_row_sum[r] <= RowW'(r_prod[r*3]) + RowW'(r_prod[r*3+1])
                              + RowW'(r_prod[r*3+2]);
            end
            r_s2_last <= r_s1_last;

            r_sum     <= SumW'(r_row_sum[0]) + SumW'(r_row_sum[1]) + SumW'(r_row_sum[2]);
            r_s3_last <= r_s2_last;

            r_scaled  <= ScW'(r_sum * $signed({1'b0, i_gain}));
            r_s4_last <= r_s3_last;

            r_out      <= n_out;
            r_out_last <= r_s4_last;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.filtered   = r_out;
    assign o_res.frame_last = r_out_last;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_s4_valid) && $stable(r_s1_valid)))
        else $error("back pipeline moved while the output was stalled");

    a_s4_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4_valid && w_adv) |=> r_out_valid)
        else $error("result lost between scaling and output");

    a_stall_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready && r_s4_valid) |=> $stable(r_scaled))
        else $error("scaled sum changed during a stall");

endmodule

/* hw/rtl/conv3x3_image_filter.sv */
// Top level of the streaming 3x3 convolution filter with line stores.
//
// Pixels enter in raster order on i_pix; every pixel whose 3x3 neighborhood
// is complete (row and column of the newest pixel both at least 2) gives one
// result on o_res, the scaled and saturated sum as a signed 24-bit integer, and
// the last result of a frame carries frame_last. Sustained rate is one pixel
// per clock as long as o_res is taken; the four-entry window queue between
// the line-store front and the arithmetic back absorbs short output stalls.
// A pixel reads the line stores at its transfer and its window enters the
// queue in the next cycle; the window can leave the queue on the next edge and
// its result is then registered through products, row sums, total, gain
// multiply, and round and clip, a chain that stalls as a whole while a
// result waits on o_res. The line stores need no clearing after reset.
// The user must write the registers on i_cfg only while the block is idle;
// the block itself does not enforce this. i_cfg.ready is high outside
// reset, and i_pix.ready stays low during reset.
module conv3x3_image_filter import c3f_pkg::*; #(
    parameter int MAX_WIDTH  = 32768,
    parameter int PIXEL_BITS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    c3f_pix_if.sink    i_pix,
    c3f_cfg_if.sink    i_cfg,
    c3f_res_if.source  o_res
);

    localparam int QWidth = WinTaps * PIXEL_BITS + 1;

    t_coef_set r_coef;
    t_geom     r_geom;
    logic [23:0] r_gain;

    logic                               w_push;
    logic [WinTaps-1:0][PIXEL_BITS-1:0] w_push_win;
    logic                               w_push_last;
    logic [QCntW-1:0]                   w_q_count;
    logic                               w_q_valid;
    logic                               w_pop;
    logic [QWidth-1:0]                  w_q_data;

    // Configuration registers
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.top    <= CoefTopRst;
            r_coef.mid    <= CoefMidRst;
            r_coef.bot    <= CoefBotRst;
            r_geom.width  <= WidthRst;
            r_geom.height <= HeightRst;
            r_gain        <= GainRst;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_COEF_TOP: r_coef.top    <= i_cfg.data;
                CFG_COEF_MID: r_coef.mid    <= i_cfg.data;
                CFG_COEF_BOT: r_coef.bot    <= i_cfg.data;
                CFG_WIDTH:    r_geom.width  <= i_cfg.data[15:0];
                CFG_HEIGHT:   r_geom.height <= i_cfg.data[15:0];
                CFG_GAIN:     r_gain        <= i_cfg.data;
                default: ;
            endcase
        end
    end

    c3f_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_geom      (r_geom),
        .i_q_count   (w_q_count),
        .o_push      (w_push),
        .o_push_win  (w_push_win),
        .o_push_last (w_push_last)
    );

    c3f_queue #(
        .WIDTH (QWidth)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data ({w_push_last, w_push_win}),
        .o_count     (w_q_count),
        .o_pop_valid (w_q_valid),
        .i_pop       (w_pop),
        .o_pop_data  (w_q_data)
    );

    c3f_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_coef    (r_coef),
        .i_gain    (r_gain),
        .i_q_valid (w_q_valid),
        .i_q_win   (w_q_data[QWidth-2:0]),
        .i_q_last  (w_q_data[QWidth-1]),
        .o_pop     (w_pop),
        .o_res     (o_res)
    );

endmodule

/* tb/c3f_result_check.sv */
`timescale 1ns / 1ps
// Result checker of the 3x3 convolution filter: predicts from observed transfers and compares.
module c3f_result_check import c3f_pkg::*; #(
    parameter int MAX_WIDTH  = 32768,
    parameter int PIXEL_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_pix_valid,
    input  logic                   i_pix_ready,
    input  logic [PIXEL_BITS-1:0]  i_pixel,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CfgIdxW-1:0]     i_cfg_index,
    input  logic [CfgDataW-1:0]    i_cfg_data,
    input  logic                   i_res_valid,
    input  logic                   i_res_ready,
    input  logic signed [OutW-1:0] i_filtered,
    input  logic                   i_frame_last,
    output int                     o_pending,
    output int                     o_mismatches
);

    typedef struct {
        logic signed [OutW-1:0] filtered;
        logic                   frame_last;
    } t_filtered;

    // Register copies as last written
    logic [23:0] coef_top, coef_mid, coef_bot, gain;
    logic [15:0] width_cfg, height_cfg;

    // Previous row and the row before it, indexed by column
    logic [PIXEL_BITS-1:0] prev_row  [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] older_row [MAX_WIDTH];
    // Window columns, top to bottom
    logic [PIXEL_BITS-1:0] ctr_col  [3];
    logic [PIXEL_BITS-1:0] left_col [3];
    int unsigned col_cnt, row_cnt;

    t_filtered filtered_q [$];
    t_filtered next_res, oldest;
    int        mismatch_cnt = 0;
    int        result_cnt   = 0;

    // One kernel row against three pixels, left coefficient in the low byte
    function automatic longint row_dot(input logic [23:0] coefs,
                                       input logic [PIXEL_BITS-1:0] pl, pc, pr);
        logic signed [7:0] kl, kc, kr;
        kl = coefs[7:0];
        kc = coefs[15:8];
        kr = coefs[23:16];
        return longint'(kl) * longint'(pl) + longint'(kc) * longint'(pc)
             + longint'(kr) * longint'(pr);
    endfunction

    // Advance the window by one pixel; return 1 when a result comes out
    function automatic bit convolve_pixel(input logic [PIXEL_BITS-1:0] px,
                                          output t_filtered res);
        int unsigned           w, h, idx;
        logic [PIXEL_BITS-1:0] top, mid;
        bit                    row_end, frame_end, emit;
        longint                sum, scaled;
        w = width_cfg;
        if (w < 3) w = 3;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = height_cfg;
        if (h < 3) h = 3;
        idx = col_cnt % MAX_WIDTH;
        top = older_row[idx];
        mid = prev_row[idx];
        older_row[idx] = mid;
        prev_row[idx]  = px;
        row_end   = col_cnt >= w - 1;
        frame_end = row_end && row_cnt >= h - 1;
        emit      = row_cnt >= 2 && col_cnt >= 2;
        res.filtered   = '0;
        res.frame_last = 1'b0;
        if (emit) begin
            sum = row_dot(coef_top, left_col[0], ctr_col[0], top)
                + row_dot(coef_mid, left_col[1], ctr_col[1], mid)
                + row_dot(coef_bot, left_col[2], ctr_col[2], px);
            // Scale, round half up, clip
            scaled = (sum * longint'(gain) + RoundBias) >>> FracDrop;
            if (scaled > OutMax) scaled = OutMax;
            if (scaled < OutMin) scaled = OutMin;
            res.filtered   = OutW'(scaled);
            res.frame_last = frame_end;
        end
        left_col   = ctr_col;
        ctr_col[0] = top;
        ctr_col[1] = mid;
        ctr_col[2] = px;
        if (row_end) begin
            col_cnt = 0;
            row_cnt = frame_end ? 0 : row_cnt + 1;
        end else begin
            col_cnt = col_cnt + 1;
        end
        return emit;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            coef_top   = CoefTopRst;
            coef_mid   = CoefMidRst;
            coef_bot   = CoefBotRst;
            width_cfg  = WidthRst;
            height_cfg = HeightRst;
            gain       = GainRst;
            ctr_col    = '{default: '0};
            left_col   = '{default: '0};
            col_cnt    = 0;
            row_cnt    = 0;
            filtered_q.delete();
        end else begin
            // Compare each result transfer with the oldest prediction
            if (i_res_valid && i_res_ready) begin
                result_cnt++;
                if (filtered_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("result %0d: unexpected, filtered %0d frame_last %0b",
                                 result_cnt, i_filtered, i_frame_last);
                end else begin
                    oldest = filtered_q.pop_front();
                    if (oldest.filtered !== i_filtered || oldest.frame_last !== i_frame_last)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("result %0d: filtered %0d frame_last %0b, %s %0d / %0b",
                                     result_cnt, i_filtered, i_frame_last, "expected",
                                     oldest.filtered, oldest.frame_last);
                    end
                end
            end
            // Track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_COEF_TOP: coef_top   = i_cfg_data[23:0];
                    CFG_COEF_MID: coef_mid   = i_cfg_data[23:0];
                    CFG_COEF_BOT: coef_bot   = i_cfg_data[23:0];
                    CFG_WIDTH:    width_cfg  = i_cfg_data[15:0];
                    CFG_HEIGHT:   height_cfg = i_cfg_data[15:0];
                    CFG_GAIN:     gain       = i_cfg_data[23:0];
                    default: ;
                endcase
            end
            // Predict from each pixel transfer
            if (i_pix_valid && i_pix_ready) begin
                if (convolve_pixel(i_pixel, next_res))
                    filtered_q.push_back(next_res);
            end
        end
        o_pending    <= filtered_q.size();
        o_mismatches <= mismatch_cnt;
    end

endmodule

/* tb/conv3x3_image_filter_tb.sv */
`timescale 1ns / 1ps
// Top of the 3x3 convolution filter testbench: clock, reset, stimulus and verdict.
module conv3x3_image_filter_tb import c3f_pkg::*; ();

    localparam int     MAX_WIDTH     = 32768;
    localparam int     PIXEL_BITS    = 12;
    localparam int     RANDOM_PIXELS = 1500;
    localparam int     DRAIN_CYCLES  = 16;
    localparam longint CYCLE_LIMIT   = 1_500_000;

    // Pixels of a 4-wide frame whose two results are rounding ties, one of each sign
    localparam logic [11:0] TIE_PIXELS [11] = '{
        12'd4095, 12'd4095, 12'd0, 12'd0,
        12'd0,    12'd4095, 12'd1, 12'd0,
        12'd4095, 12'd0,    12'd4095
    };

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    int     snd_idle_pct = 26;
    int     rcv_idle_pct = 52;
    int     pending_cnt;
    int     mismatch_cnt;
    int     random_sent = 0;
    int     frame_px;
    longint cycle_cnt = 0;
    logic [15:0] width_fld, height_fld;

    c3f_pix_if #(.PIXEL_BITS(PIXEL_BITS)) pix_if ();
    c3f_cfg_if cfg_if ();
    c3f_res_if res_if ();

    conv3x3_image_filter #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    c3f_result_check #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (pix_if.valid),
        .i_pix_ready  (pix_if.ready),
        .i_pixel      (pix_if.pixel),
        .i_cfg_valid  (cfg_if.valid),
        .i_cfg_ready  (cfg_if.ready),
        .i_cfg_index  (cfg_if.index),
        .i_cfg_data   (cfg_if.data),
        .i_res_valid  (res_if.valid),
        .i_res_ready  (res_if.ready),
        .i_filtered   (res_if.filtered),
        .i_frame_last (res_if.frame_last),
        .o_pending    (pending_cnt),
        .o_mismatches (mismatch_cnt)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("conv3x3_image_filter verification failed");
            $finish;
        end
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        res_if.ready <= i_rst_n && ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    function automatic logic [11:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return 12'd0;
            1:       return 12'hFFF;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] rand_coef_row();
        case ($urandom_range(0, 7))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'h7F7F7F;
            3:       return 24'h808080;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom >> $urandom_range(8, 31));
        endcase
    endfunction

    // Write one register; upper data bits beyond the register width are noise
    task automatic write_reg(input t_cfg_idx idx, input logic [23:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Offer one pixel after an optional gap and hold it until the transfer
    task automatic push_pixel(input logic [11:0] px);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= px;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every predicted result, then let the pipeline empty
    task automatic drain_results();
        pix_if.valid <= 1'b0;
        while (pending_cnt != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write the geometry and send one whole frame of random pixels
    task automatic send_frame(input logic [15:0] wf, input logic [15:0] hf, output int sent);
        int w, h;
        w = wf;
        if (w < 3) w = 3;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = hf;
        if (h < 3) h = 3;
        write_reg(CFG_WIDTH, {8'($urandom), wf});
        write_reg(CFG_HEIGHT, {8'($urandom), hf});
        repeat (w * h) push_pixel(rand_pixel());
        sent = w * h;
        drain_results();
    endtask

    initial begin
        pix_if.valid = 1'b0;
        pix_if.pixel = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_COEF_TOP;
        cfg_if.data  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Smallest frame, full-scale pixels and kernel: clip high
        write_reg(CFG_WIDTH, 24'd2);
        write_reg(CFG_HEIGHT, 24'd0);
        write_reg(CFG_COEF_TOP, 24'h7F7F7F);
        write_reg(CFG_COEF_MID, 24'h7F7F7F);
        write_reg(CFG_COEF_BOT, 24'h7F7F7F);
        write_reg(CFG_GAIN, 24'hFFFFFF);
        repeat (9) push_pixel(12'hFFF);
        drain_results();

        // Half gain gives rounding ties; geometry shrinks partway through the frame
        write_reg(CFG_WIDTH, 24'd4);
        write_reg(CFG_HEIGHT, 24'h00FFFF);
        write_reg(CFG_COEF_TOP, 24'h800080);
        write_reg(CFG_COEF_MID, 24'h000100);
        write_reg(CFG_COEF_BOT, 24'h7E007E);
        write_reg(CFG_GAIN, 24'd32768);
        foreach (TIE_PIXELS[i]) push_pixel(TIE_PIXELS[i]);
        drain_results();
        write_reg(CFG_WIDTH, 24'd3);
        write_reg(CFG_HEIGHT, 24'd1);
        push_pixel(12'd0);
        drain_results();

        // Random frames over three idling phases
        while (random_sent < RANDOM_PIXELS) begin
            if (random_sent >= 2 * RANDOM_PIXELS / 3) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end else if (random_sent >= RANDOM_PIXELS / 3) begin
                snd_idle_pct = 52;
                rcv_idle_pct = 26;
            end
            if ($urandom_range(0, 3) != 0) write_reg(CFG_COEF_TOP, rand_coef_row());
            if ($urandom_range(0, 3) != 0) write_reg(CFG_COEF_MID, rand_coef_row());
            if ($urandom_range(0, 3) != 0) write_reg(CFG_COEF_BOT, rand_coef_row());
            if ($urandom_range(0, 3) != 0) write_reg(CFG_GAIN, rand_gain());
            width_fld  = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 2))
                                                     : 16'($urandom_range(3, 10));
            height_fld = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 2))
                                                     : 16'($urandom_range(3, 6));
            send_frame(width_fld, height_fld, frame_px);
            random_sent += frame_px;
        end

        // Longer rows than the random frames use
        write_reg(CFG_COEF_TOP, rand_coef_row());
        write_reg(CFG_COEF_MID, rand_coef_row());
        write_reg(CFG_COEF_BOT, rand_coef_row());
        write_reg(CFG_GAIN, rand_gain());
        send_frame(16'd40, 16'd3, frame_px);

        if (mismatch_cnt == 0 && pending_cnt == 0) begin
            $display("conv3x3_image_filter verification clean");
        end else begin
            $display("conv3x3_image_filter verification failed");
        end
        $finish;
    end

endmodule
